// ----- hw/rtl/salru_pkg.sv -----
`default_nettype none
package salru_pkg;

  localparam int ADDR_W       = 64;
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 4;
  localparam int WAYS_W       = 4;
  localparam int SHAMT_W      = 5;
  localparam int FIELD_W      = (1 << SET_BITS_W) - 1;
  localparam int FIELD_DEPTH  = 1 << FIELD_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int COUNT_W      = 32;
  localparam int OUT_WAY_W    = 3;

  localparam int SET_COUNT_DEF = 64;
  localparam int NUM_WAYS_DEF  = 8;
  localparam int AGE_WIDTH_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_reg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/salru_decode.sv -----
`default_nettype none
module salru_decode #(
  parameter int SET_COUNT = salru_pkg::SET_COUNT_DEF
) (
  input  logic                                             clk,
  input  logic [salru_pkg::ADDR_W-1:0]                     addr,
  input  logic [salru_pkg::SET_BITS_W-1:0]                 set_bits,
  input  logic [salru_pkg::BLOCK_BITS_W-1:0]               block_bits,
  output logic [(SET_COUNT > 1 ? $clog2(SET_COUNT) : 1)-1:0] set_idx,
  output logic [salru_pkg::ADDR_W-1:0]                     tag
);
  import salru_pkg::*;

  localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;

  logic [FIELD_W:0]   one_hot;
  logic [FIELD_W-1:0] mask;
  logic [SHAMT_W-1:0] shamt;
  logic [ADDR_W-1:0]  shifted;
  logic [FIELD_W-1:0] field;
  logic [SET_W-1:0]   mod_tab [FIELD_DEPTH];

  assign one_hot = (FIELD_W + 1)'(1) << set_bits;
  assign mask    = FIELD_W'(one_hot - (FIELD_W + 1)'(1));
  assign shamt   = SHAMT_W'(set_bits) + SHAMT_W'(block_bits);
  assign shifted = addr >> block_bits;

  // set field modulo set count
  for (genvar gi = 0; gi < FIELD_DEPTH; gi++) begin : g_mod
    assign mod_tab[gi] = SET_W'(gi % SET_COUNT);
  end

  always_ff @(posedge clk) begin
    field   <= shifted[FIELD_W-1:0] & mask;
    tag     <= addr >> shamt;
    set_idx <= mod_tab[field];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/set_assoc_lru_cache_tags_unit.sv -----
`default_nettype none
// channel  direction  handshake              payload
// in       to block   in_valid / in_stall    address
// out      from block out_valid / out_stall  hit evicted way evicted_tag *_total
// cfg      to block   cfg_valid / cfg_ready  cfg_index cfg_data
//
// After reset a clearing pass writes all 2^(SET_W+WAY_W) memory lines
// (512 at the defaults); no address word is taken meanwhile.
// An item passes DEC1, DEC2, SCAN, FILL on a miss only, and DONE. SCAN reads
// the ways in use in turn: one line memory port, one compare/age unit.
// A result waiting on out_stall does not block the next address word.
module set_assoc_lru_cache_tags_unit #(
  parameter int SET_COUNT = salru_pkg::SET_COUNT_DEF,
  parameter int NUM_WAYS  = salru_pkg::NUM_WAYS_DEF,
  parameter int AGE_WIDTH = salru_pkg::AGE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [salru_pkg::ADDR_W-1:0]     address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic                             evicted,
  output logic [salru_pkg::OUT_WAY_W-1:0]  way,
  output logic [salru_pkg::ADDR_W-1:0]     evicted_tag,
  output logic [salru_pkg::COUNT_W-1:0]    hit_total,
  output logic [salru_pkg::COUNT_W-1:0]    miss_total,
  output logic [salru_pkg::COUNT_W-1:0]    eviction_total,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0] cfg_data
);
  import salru_pkg::*;

  localparam int SET_W   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int NW_W    = $clog2(NUM_WAYS + 1);
  localparam int MADDR_W = SET_W + WAY_W;
  localparam int DEPTH   = 1 << MADDR_W;
  localparam int ENTRY_W = 1 + ADDR_W + AGE_WIDTH;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DEC1, ST_DEC2, ST_SCAN, ST_FILL, ST_DONE
  } state_t;

  state_t state;

  logic [MADDR_W-1:0]      clr_cnt;
  logic [ADDR_W-1:0]       addr_q;
  logic [SET_BITS_W-1:0]   set_bits;
  logic [BLOCK_BITS_W-1:0] block_bits;
  logic [WAYS_W-1:0]       ways_in_use;
  logic [SET_W-1:0]        set_idx;
  logic [ADDR_W-1:0]       tag_q;

  logic [NW_W-1:0]         nways;
  logic [NW_W-1:0]         iw;
  logic                    pend;
  logic [WAY_W-1:0]        pw;
  logic                    hit_f;
  logic                    inv_f;
  logic [WAY_W-1:0]        inv_way;
  logic [AGE_WIDTH-1:0]    best_age;
  logic [WAY_W-1:0]        best_way;
  logic [ADDR_W-1:0]       best_tag;
  logic [WAY_W-1:0]        way_r;
  logic                    evict_r;
  logic [ADDR_W-1:0]       old_tag;
  logic [COUNT_W-1:0]      hits;
  logic [COUNT_W-1:0]      misses;
  logic [COUNT_W-1:0]      evictions;
  logic [COUNT_W-1:0]      hits_next;
  logic [COUNT_W-1:0]      misses_next;
  logic [COUNT_W-1:0]      evictions_next;

  logic [ENTRY_W-1:0]      mem [DEPTH];
  logic [ENTRY_W-1:0]      rdata;
  logic [MADDR_W-1:0]      raddr;
  logic                    we;
  logic [MADDR_W-1:0]      waddr;
  logic [ENTRY_W-1:0]      wdata;

  logic                    issue;
  logic                    r_valid;
  logic [ADDR_W-1:0]       r_tag;
  logic [AGE_WIDTH-1:0]    r_age;
  logic [AGE_WIDTH-1:0]    aged;
  logic                    is_match;
  logic [WAY_W-1:0]        fill_way;

  salru_decode #(
    .SET_COUNT(SET_COUNT)
  ) u_decode (
    .clk       (clk),
    .addr      (addr_q),
    .set_bits  (set_bits),
    .block_bits(block_bits),
    .set_idx   (set_idx),
    .tag       (tag_q)
  );

  always_comb begin
    if (ways_in_use == '0) begin
      nways = NW_W'(1);
    end else if (int'(ways_in_use) > NUM_WAYS) begin
      nways = NW_W'(NUM_WAYS);
    end else begin
      nways = NW_W'(ways_in_use);
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign issue    = (state == ST_SCAN) && (iw != nways);
  assign raddr    = {set_idx, iw[WAY_W-1:0]};
  assign r_valid  = rdata[ENTRY_W-1];
  assign r_tag    = rdata[AGE_WIDTH +: ADDR_W];
  assign r_age    = rdata[AGE_WIDTH-1:0];
  assign aged     = (r_age == '1) ? r_age : r_age + AGE_WIDTH'(1);
  assign is_match = r_valid && !hit_f && (r_tag == tag_q);
  assign fill_way = inv_f ? inv_way : best_way;

  assign hits_next      = (hit_f && hits != '1) ? hits + COUNT_W'(1) : hits;
  assign misses_next    = (!hit_f && misses != '1) ? misses + COUNT_W'(1) : misses;
  assign evictions_next = (evict_r && evictions != '1) ? evictions + COUNT_W'(1)
                                                         : evictions;

  always_comb begin
    we    = 1'b0;
    waddr = {set_idx, pw};
    wdata = '0;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      ST_SCAN: begin
        if (pend && r_valid) begin
          we    = 1'b1;
          wdata = {1'b1, r_tag, (is_match ? {AGE_WIDTH{1'b0}} : aged)};
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = {set_idx, fill_way};
        wdata = {1'b1, tag_q, {AGE_WIDTH{1'b0}}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      set_bits    <= '0;
      block_bits  <= '0;
      ways_in_use <= WAYS_W'(1);
      pend        <= 1'b0;
      hit_f       <= 1'b0;
      inv_f       <= 1'b0;
      hits        <= '0;
      misses      <= '0;
      evictions   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits    <= cfg_data[SET_BITS_W-1:0];
          CFG_BLOCK_BITS: block_bits  <= cfg_data[BLOCK_BITS_W-1:0];
          CFG_WAYS:       ways_in_use <= cfg_data[WAYS_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + MADDR_W'(1);
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            addr_q <= address;
            state  <= ST_DEC1;
          end
        end
        ST_DEC1: state <= ST_DEC2;
        ST_DEC2: begin
          iw    <= '0;
          pend  <= 1'b0;
          hit_f <= 1'b0;
          inv_f <= 1'b0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          pend <= issue;
          if (issue) begin
            pw <= iw[WAY_W-1:0];
            iw <= iw + NW_W'(1);
          end
          if (pend) begin
            if (is_match) begin
              hit_f <= 1'b1;
              way_r <= pw;
            end
            if (!r_valid && !inv_f) begin
              inv_f   <= 1'b1;
              inv_way <= pw;
            end
            // oldest line, lowest way on a tie
            if (pw == '0 || aged > best_age) begin
              best_age <= aged;
              best_way <= pw;
              best_tag <= r_tag;
            end
          end
          if (!issue && !pend) begin
            evict_r <= 1'b0;
            old_tag <= '0;
            state   <= hit_f ? ST_DONE : ST_FILL;
          end
        end
        ST_FILL: begin
          way_r   <= fill_way;
          evict_r <= !inv_f;
          old_tag <= inv_f ? '0 : best_tag;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            hits           <= hits_next;
            misses         <= misses_next;
            evictions      <= evictions_next;
            hit            <= hit_f;
            evicted        <= evict_r;
            way            <= OUT_WAY_W'(way_r);
            evicted_tag    <= old_tag;
            hit_total      <= hits_next;
            miss_total     <= misses_next;
            eviction_total <= evictions_next;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
